// File: design/lsd_pkg.sv
// Shared constants and types for the LRU stack distance block.
package lsd_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int ADDR_W          = 32;
    localparam int DIST_W          = 10;
    localparam int LIMIT_W         = 11;
    localparam int LIMIT_RESET     = 1024;
    localparam int DIST_MAX        = 1023;
    // Tree levels between pipeline registers in the position encoder.
    localparam int ENC_STAGE       = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEARCH
    } t_state;

endpackage

// File: design/lsd_cell.sv
// One stack cell: holds an entry, compares it with the lookup address, shifts on update.
module lsd_cell #(
    parameter int STACK_DEPTH = lsd_pkg::STACK_DEPTH_DEF,
    parameter int INDEX       = 0
) (
    input  logic                          i_clk,
    input  logic                          i_update,
    input  logic [lsd_pkg::ADDR_W-1:0]    i_prev,
    input  logic [lsd_pkg::ADDR_W-1:0]    i_addr,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_fill,
    input  logic [$clog2(STACK_DEPTH)-1:0]   i_top,
    output logic [lsd_pkg::ADDR_W-1:0]    o_entry,
    output logic                          o_match
);
    import lsd_pkg::*;

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(STACK_DEPTH);

    logic [ADDR_W-1:0] r_entry;
    logic              r_match;

    // only cells below the fill count hold live entries
    always_ff @(posedge i_clk) begin
        r_match <= (r_entry == i_addr) && (FW'(INDEX) < i_fill);
    end

    // take the neighbor's entry when this cell lies at or above the shift boundary
    always_ff @(posedge i_clk) begin
        if (i_update && (PW'(INDEX) <= i_top)) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// File: design/lsd_enc.sv
// Pipelined one-hot to binary encoder over the cell match flags.
module lsd_enc #(
    parameter int STACK_DEPTH = lsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic [STACK_DEPTH-1:0]         i_match,
    output logic                           o_hit,
    output logic [$clog2(STACK_DEPTH)-1:0] o_pos
);
    import lsd_pkg::*;

    localparam int PW = $clog2(STACK_DEPTH);
    localparam int NP = 1 << PW;

    // node = {any match below, index of that match}
    logic [PW:0] w_node [PW+1][NP];

    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < STACK_DEPTH) begin : g_live
            assign w_node[0][j] = {i_match[j], {PW{1'b0}}};
        end else begin : g_pad
            assign w_node[0][j] = '0;
        end
    end

    for (genvar l = 1; l <= PW; l++) begin : g_lvl
        for (genvar j = 0; j < NP; j++) begin : g_node
            if (j < (NP >> l)) begin : g_used
                localparam logic [PW-1:0] LVL_BIT = PW'(1 << (l - 1));
                logic [PW:0] w_left;
                logic [PW:0] w_right;
                logic [PW:0] w_merge;
                assign w_left  = w_node[l-1][2*j];
                assign w_right = w_node[l-1][2*j+1];
                // matches are one-hot, so the index bits simply OR together
                assign w_merge = {w_left[PW] | w_right[PW],
                                  w_left[PW-1:0] | w_right[PW-1:0]
                                  | (w_right[PW] ? LVL_BIT : '0)};
                if ((l % ENC_STAGE) == 0) begin : g_reg
                    logic [PW:0] r_node;
                    always_ff @(posedge i_clk) begin
                        r_node <= w_merge;
                    end
                    assign w_node[l][j] = r_node;
                end else begin : g_comb
                    assign w_node[l][j] = w_merge;
                end
            end else begin : g_unused
                assign w_node[l][j] = '0;
            end
        end
    end

    assign o_hit = w_node[PW][0][PW];
    assign o_pos = w_node[PW][0][PW-1:0];

endmodule

// File: design/lru_stack_distance.sv
// Top level of the bounded LRU stack distance unit.
//
// Each input item carries one address. The unit looks it up in a stack of
// recently used addresses held in a chain of STACK_DEPTH cells, cell 0 being
// the most recent. A hit returns the cell position (the stack distance,
// saturated to 1023) with miss low; a miss returns distance 0 with miss high.
// The address then goes to cell 0 while the cells above the old position (or
// above the fill count on a miss) shift down by one, all in the same cycle; when
// the stack is at its limit the least recent entry drops off. The limit
// register (i_cfg_wdata) treats 0 as 1 and saturates at STACK_DEPTH; lowering
// it below the current fill drops the oldest entries at the next item.
// One item is handled at a time: the accept, the compare step in which every
// cell compares and registers its match flag, then the encoder tree that
// turns the match flags into a position, with a register every four tree
// levels, and the shift, which waits until the output register is free.
// The result sits in an output register, so a new item is taken while the
// last result waits. Stack contents need no clearing after reset; the fill
// count marks what is live.
module lru_stack_distance #(
    parameter int STACK_DEPTH = lsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [lsd_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lsd_pkg::ADDR_W-1:0]    i_address,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lsd_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_miss
);
    import lsd_pkg::*;

    localparam int FW         = $clog2(STACK_DEPTH + 1);
    localparam int PW         = $clog2(STACK_DEPTH);
    localparam int LW         = (FW > LIMIT_W) ? FW : LIMIT_W;
    localparam int TREE_LAT   = PW / ENC_STAGE;
    localparam int CW         = $clog2(TREE_LAT + 2);
    localparam int LIMIT_INIT = (LIMIT_RESET > STACK_DEPTH) ? STACK_DEPTH : LIMIT_RESET;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_limit;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_distance;
    logic              r_miss;

    logic              w_accept;
    logic              w_update;
    logic              w_out_free;
    logic              w_hit;
    logic [PW-1:0]     w_pos;
    logic [FW-1:0]     w_fill_new;
    logic [PW-1:0]     w_top;
    logic [LW-1:0]     w_lim_raw;
    logic [FW-1:0]     w_lim_eff;

    logic [ADDR_W-1:0]      w_entry [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] w_match;

    // ---------------------------------------------------------------
    // Limit register: map 0 to 1, saturate at the stack depth
    // ---------------------------------------------------------------
    always_comb begin
        w_lim_raw = LW'(i_cfg_wdata);
        if (w_lim_raw == '0) begin
            w_lim_raw = LW'(1);
        end
        if (w_lim_raw > LW'(STACK_DEPTH)) begin
            w_lim_raw = LW'(STACK_DEPTH);
        end
        w_lim_eff = FW'(w_lim_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= FW'(LIMIT_INIT);
        end else if (i_cfg_we) begin
            r_limit <= w_lim_eff;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        w_update = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // match flags register at the end of this cycle
                n_state = S_SEARCH;
                n_cnt   = '0;
            end
            S_SEARCH: begin
                if (r_cnt == CW'(TREE_LAT)) begin
                    // position is settled; hold until the output slot frees up
                    if (w_out_free) begin
                        w_update = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Address latch and fill count
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= i_address;
        end
    end

    assign w_fill_new = (r_fill < r_limit) ? r_fill + 1'b1 : r_fill;
    // deepest cell that takes its neighbor's entry on this update
    assign w_top      = w_hit ? w_pos : PW'(w_fill_new - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            // drop the oldest entries if the limit was lowered
            if (r_fill > r_limit) begin
                r_fill <= r_limit;
            end
        end else if (w_update && !w_hit) begin
            r_fill <= w_fill_new;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain: cell 0 is fed by the lookup address
    // ---------------------------------------------------------------
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [ADDR_W-1:0] w_prev;
        if (i == 0) begin : g_head
            assign w_prev = r_addr;
        end else begin : g_body
            assign w_prev = w_entry[i-1];
        end
        lsd_cell #(
            .STACK_DEPTH (STACK_DEPTH),
            .INDEX       (i)
        ) u_cell (
            .i_clk    (i_clk),
            .i_update (w_update),
            .i_prev   (w_prev),
            .i_addr   (r_addr),
            .i_fill   (r_fill),
            .i_top    (w_top),
            .o_entry  (w_entry[i]),
            .o_match  (w_match[i])
        );
    end

    lsd_enc #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_enc (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_hit   (w_hit),
        .o_pos   (w_pos)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_miss <= !w_hit;
            if (!w_hit) begin
                r_distance <= '0;
            end else if (32'(w_pos) > 32'(DIST_MAX)) begin
                r_distance <= DIST_W'(DIST_MAX);
            end else begin
                r_distance <= DIST_W'(w_pos);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_miss      = r_miss;

`ifndef SYNTHESIS
    a_accept_starts_lookup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CMP))
        else $error("accepted item did not start a lookup");

    a_fill_within_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_update |=> (r_fill <= $past(r_limit)))
        else $error("fill count exceeds stack limit after update");

    a_hit_below_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_update && w_hit) |-> (FW'(w_pos) < r_fill))
        else $error("hit position outside live entries");

    a_result_from_search : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SEARCH))
        else $error("result produced outside search state");
`endif

endmodule

// File: test/lsd_checker.sv
// Checker for the LRU stack distance unit: tracks the stack, predicts each lookup, compares.
`timescale 1ns / 1ps

module lsd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lsd_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [lsd_pkg::ADDR_W-1:0]   i_address,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [lsd_pkg::DIST_W-1:0]   i_distance,
    input  logic                         i_miss,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_hits,
    output int                           o_misses
);
    import lsd_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              miss;
    } t_lookup;

    logic [ADDR_W-1:0]  lru_stack [DEPTH];
    int                 lru_fill;
    logic [LIMIT_W-1:0] limit_reg;
    t_lookup            expected_lookups [$];
    int                 result_idx;

    // Look the address up, move it to the top and return the stack distance.
    task automatic lookup_and_promote(input logic [ADDR_W-1:0] addr, output t_lookup res);
        int  lim;
        int  pos;
        bit  hit;
        lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : int'(limit_reg));
        // a lowered limit trims the oldest entries before the search
        if (lru_fill > lim)
            lru_fill = lim;
        hit = 1'b0;
        pos = 0;
        for (int i = 0; i < lru_fill; i++) begin
            if (!hit && lru_stack[i] == addr) begin
                hit = 1'b1;
                pos = i;
            end
        end
        if (hit) begin
            for (int i = pos; i > 0; i--)
                lru_stack[i] = lru_stack[i-1];
            res.distance = (pos > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(pos);
            res.miss     = 1'b0;
        end else begin
            if (lru_fill < lim)
                lru_fill++;
            for (int i = lru_fill - 1; i > 0; i--)
                lru_stack[i] = lru_stack[i-1];
            res.distance = '0;
            res.miss     = 1'b1;
        end
        lru_stack[0] = addr;
    endtask

    always @(posedge i_clk) begin
        t_lookup pred;
        t_lookup want;
        if (!i_rst_n) begin
            lru_fill   = 0;
            limit_reg  = LIMIT_W'(LIMIT_RESET);
            expected_lookups.delete();
            result_idx = 0;
            o_errors   = 0;
            o_hits     = 0;
            o_misses   = 0;
        end else begin
            if (i_cfg_we)
                limit_reg = i_cfg_wdata;
            // compare before pushing so a stray result is never matched to a new item
            if (i_out_valid && !i_out_stall) begin
                if (expected_lookups.size() == 0) begin
                    if (o_errors < 10)
                        $display("[%0t] unexpected result: distance %0d miss %0d",
                                 $realtime, i_distance, i_miss);
                    o_errors++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (want.distance !== i_distance || want.miss !== i_miss) begin
                        if (o_errors < 10)
                            $display({"[%0t] result %0d: expected distance %0d miss %0d,",
                                      " got distance %0d miss %0d"},
                                     $realtime, result_idx, want.distance, want.miss,
                                     i_distance, i_miss);
                        o_errors++;
                    end
                    if (want.miss)
                        o_misses++;
                    else
                        o_hits++;
                end
                result_idx++;
            end
            if (i_in_valid && !i_in_stall) begin
                lookup_and_promote(i_address, pred);
                expected_lookups.insert(expected_lookups.size(), pred);
            end
        end
        o_pending = expected_lookups.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the LRU stack distance unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lsd_pkg::*;

    // Generous cap on the length of the run.
    localparam int CYCLE_LIMIT = 600000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_LEN    = 300;
    // Distinct addresses pushed to fill the stack up to its limit.
    localparam int FILL_N      = 160;
    // Items per random batch.
    localparam int BATCH_LEN   = 36;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [ADDR_W-1:0]  i_address;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [DIST_W-1:0]  o_distance;
    logic               o_miss;

    int errors;
    int pending;
    int hits;
    int misses;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Each increment asks the receiver for one long hold-off.
    int hold_reqs   = 0;
    int items_sent  = 0;
    int cycles      = 0;

    lru_stack_distance DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_address   (i_address),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .o_miss      (o_miss)
    );

    lsd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_address   (i_address),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_distance  (o_distance),
        .i_miss      (o_miss),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_misses    (misses)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs anywhere.
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still outstanding",
                         cycles, pending);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request. The hold-off
    // lets the output register and the unit fill up so the input stalls too.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Offer one address, with random idle cycles first; return at the accept edge.
    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding lookup has returned.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        // idle margin after the last result has been taken
        repeat (2) @(posedge i_clk);
    endtask

    // Write the stack limit while the unit is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [ADDR_W-1:0] addr_pool [64];
        logic [ADDR_W-1:0] fill_base;
        int                pool_n;
        int                lim_eff;
        logic [LIMIT_W-1:0] lim_val;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_address   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme addresses, hits at the top and deeper, at the reset limit.
        send_addr(32'h0000_0000);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'h0000_0000);
        send_addr(32'h0000_0000);
        send_addr(32'hFFFF_FFFF);
        send_addr(32'hAAAA_AAAA);
        send_addr(32'h5555_5555);
        send_addr(32'h0000_0000);

        // A limit of zero acts as one: the stack is cut to a single entry.
        write_limit('0);
        send_addr(32'hA5A5_A5A5);
        send_addr(32'hA5A5_A5A5);
        send_addr(32'h5A5A_5A5A);
        send_addr(32'hA5A5_A5A5);

        // Limit above the depth saturates; then lower it below the fill count.
        write_limit(LIMIT_W'(2047));
        send_addr(32'd1);
        send_addr(32'd2);
        send_addr(32'd3);
        send_addr(32'd4);
        write_limit(LIMIT_W'(2));
        send_addr(32'd3);
        send_addr(32'd1);

        // Fill the stack up to its limit with distinct addresses, then touch the
        // oldest, push a fresh one and touch the entry that fell off.
        write_limit(LIMIT_W'(FILL_N));
        fill_base = $urandom;
        for (int i = 0; i < FILL_N; i++)
            send_addr(fill_base + ADDR_W'(i));
        send_addr(fill_base);
        send_addr(~fill_base);
        send_addr(fill_base + ADDR_W'(1));

        // Random part: three idle mixes, five limit settings each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 6;  rx_idle_pct = 52; end
                1: begin tx_idle_pct = 52; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int batch = 0; batch < 5; batch++) begin
                case ($urandom_range(0, 5))
                    0: lim_val = '0;
                    1: lim_val = LIMIT_W'(1);
                    2: lim_val = LIMIT_W'($urandom_range(2, 8));
                    3: lim_val = LIMIT_W'(LIMIT_RESET);
                    4: lim_val = LIMIT_W'($urandom_range(LIMIT_RESET + 1, 2047));
                    default: lim_val = LIMIT_W'($urandom_range(9, DIST_MAX));
                endcase
                write_limit(lim_val);
                lim_eff = (lim_val == 0) ? 1 :
                          ((lim_val > STACK_DEPTH_DEF) ? STACK_DEPTH_DEF : int'(lim_val));
                // Pool of 1 to limit + 3 addresses, at most 64, so hits and evictions mix.
                pool_n = $urandom_range(1, (lim_eff + 3 > 64) ? 64 : lim_eff + 3);
                for (int k = 0; k < pool_n; k++)
                    addr_pool[k] = $urandom;
                // Pause the sender until all results are back, then restart.
                if (phase == 1 && batch == 2)
                    drain();
                for (int n = 0; n < BATCH_LEN; n++) begin
                    // Mid-batch, hold the receiver off while items keep coming.
                    if (phase == 0 && batch == 2 && n == 10)
                        hold_reqs++;
                    if ($urandom_range(0, 99) < 80)
                        send_addr(addr_pool[$urandom_range(0, pool_n - 1)]);
                    else
                        send_addr($urandom);
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d lookups (%0d hits, %0d misses) over stack limits 0..2047,",
                 items_sent, hits, misses);
        $display("a stack filled to its limit, three idle mixes and a long output hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/lsd_pkg.sv
design/lsd_cell.sv
design/lsd_enc.sv
design/lru_stack_distance.sv
test/lsd_checker.sv
test/tb_top.sv
